[rtl/weighted_pixel_accumulator_core_assert.svh]
// Assertion macros for the weighted pixel accumulator.
`ifndef WEIGHTED_PIXEL_ACCUMULATOR_CORE_ASSERT_SVH
`define WEIGHTED_PIXEL_ACCUMULATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define WPA_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define WPA_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define WPA_ASSERT_IMPL(label, clk, rst, prop)
`define WPA_ASSERT_NORST(label, clk, prop)
`endif
`endif

[rtl/wpa_pkg.sv]
// -----------------------------------------------------------------------------
// wpa_pkg
// Types and constants of the weighted pixel accumulator.
// -----------------------------------------------------------------------------
package wpa_pkg;
   localparam int CHAN_W = 48;
   localparam int WSUM_W = 40;
   localparam int ADDR_W = 16;
   localparam int DIV_W  = 56;
   localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};
   localparam logic [WSUM_W-1:0] WSUM_MAX = {WSUM_W{1'b1}};
   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef struct packed {
      logic        func;
      logic [7:0]  pixel_x;
      logic [7:0]  pixel_y;
      logic [15:0] red_in;
      logic [15:0] green_in;
      logic [15:0] blue_in;
      logic [15:0] sample_weight;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   // Classified command passed from the front end to the back end.
   typedef struct packed {
      logic              is_read;
      logic              in_image;
      logic [ADDR_W-1:0] addr;
      logic [15:0]       red_in;
      logic [15:0]       green_in;
      logic [15:0]       blue_in;
      logic [15:0]       sample_weight;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_ADD, ST_DIV, ST_OUT
   } be_state_type;
endpackage

[rtl/wpa_if.sv]
// -----------------------------------------------------------------------------
// wpa_req_if / wpa_rsp_if
// Valid/ready channels of the weighted pixel accumulator.
// -----------------------------------------------------------------------------
interface wpa_req_if;
   logic              valid;
   logic              ready;
   wpa_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface wpa_rsp_if;
   logic              valid;
   logic              ready;
   wpa_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/wpa_front.sv]
// -----------------------------------------------------------------------------
// wpa_front
// Accepts items, classifies them and queues commands for the back end.
// -----------------------------------------------------------------------------
module wpa_front #(
   parameter int IMG_WIDTH  = 256,
   parameter int IMG_HEIGHT = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wpa_pkg::req_type  req_item,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output wpa_pkg::cmd_type  cmd_item
);
   import wpa_pkg::*;

   localparam int DEPTH = 4;

   cmd_type      q_ff [DEPTH];
   logic [1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [2:0]   count_ff;
   cmd_type      cmd_in;
   logic         push, pop;

   always_comb begin
      cmd_in.is_read       = (req_item.func == FUNC_READ);
      cmd_in.in_image      = ({24'd0, req_item.pixel_x} < IMG_WIDTH) &&
                             ({24'd0, req_item.pixel_y} < IMG_HEIGHT);
      cmd_in.addr          = {req_item.pixel_y, req_item.pixel_x};
      cmd_in.red_in        = req_item.red_in;
      cmd_in.green_in      = req_item.green_in;
      cmd_in.blue_in       = req_item.blue_in;
      cmd_in.sample_weight = req_item.sample_weight;
   end

   assign req_ready = (count_ff != 3'(DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != 3'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_item  = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 2'd1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_ff + 3'(push) - 3'(pop);
      end
   end
endmodule

[rtl/wpa_div.sv]
// -----------------------------------------------------------------------------
// wpa_div
// Restoring divider, one quotient bit per cycle, with clamp to 255.
// -----------------------------------------------------------------------------
module wpa_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [wpa_pkg::DIV_W-1:0]  dividend,
   input  logic [wpa_pkg::DIV_W-1:0]  divisor,
   output logic                       done,
   output logic [7:0]                 result
);
   import wpa_pkg::*;

   logic [DIV_W-1:0] quo_ff, den_ff;
   logic [DIV_W:0]   rem_ff;
   logic [5:0]       cnt_ff;
   logic             busy_ff, done_ff;
   logic [DIV_W:0]   trial;

   assign trial  = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
   assign done   = done_ff;
   assign result = (quo_ff > DIV_W'(255)) ? 8'd255 : quo_ff[7:0];

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= trial - {1'b0, den_ff};
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'(DIV_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

[rtl/wpa_back.sv]
// -----------------------------------------------------------------------------
// wpa_back
// Film store, clearing pass, read-modify-write of samples and pixel resolve.
// -----------------------------------------------------------------------------
module wpa_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  wpa_pkg::cmd_type  cmd_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wpa_pkg::rsp_type  rsp_item,
   output logic              clearing
);
   import wpa_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   logic [CHAN_W-1:0] red_mem [DEPTH];
   logic [CHAN_W-1:0] grn_mem [DEPTH];
   logic [CHAN_W-1:0] blu_mem [DEPTH];
   logic [WSUM_W-1:0] wgt_mem [DEPTH];

   be_state_type      state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff;
   cmd_type           cmd_ff;
   logic [CHAN_W-1:0] red_rd_ff, grn_rd_ff, blu_rd_ff;
   logic [WSUM_W-1:0] wgt_rd_ff;
   logic [31:0]       rp_ff, gp_ff, bp_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;
   logic              div_ok_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CHAN_W-1:0] red_wr, grn_wr, blu_wr;
   logic [WSUM_W-1:0] wgt_wr;
   logic [CHAN_W:0]   rs, gs, bs;
   logic [WSUM_W:0]   ws;
   logic              div_start;
   logic [DIV_W-1:0]  divisor;
   logic              rd_done, gd_done, bd_done;
   logic [7:0]        rq, gq, bq;

   assign clearing  = (state_ff == ST_CLEAR);
   assign cmd_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign rs = {1'b0, red_rd_ff} + {17'd0, rp_ff};
   assign gs = {1'b0, grn_rd_ff} + {17'd0, gp_ff};
   assign bs = {1'b0, blu_rd_ff} + {17'd0, bp_ff};
   assign ws = {1'b0, wgt_rd_ff} + {25'd0, cmd_ff.sample_weight};

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cmd_ff.addr;
      red_wr  = rs[CHAN_W] ? CHAN_MAX : rs[CHAN_W-1:0];
      grn_wr  = gs[CHAN_W] ? CHAN_MAX : gs[CHAN_W-1:0];
      blu_wr  = bs[CHAN_W] ? CHAN_MAX : bs[CHAN_W-1:0];
      wgt_wr  = ws[WSUM_W] ? WSUM_MAX : ws[WSUM_W-1:0];
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         red_wr  = '0;
         grn_wr  = '0;
         blu_wr  = '0;
         wgt_wr  = '0;
      end else if (state_ff == ST_ADD) begin
         wr_en = 1'b1;
      end
   end

   // The sums are read once, when a command is taken, and held until it is done.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         red_mem[wr_addr] <= red_wr;
         grn_mem[wr_addr] <= grn_wr;
         blu_mem[wr_addr] <= blu_wr;
         wgt_mem[wr_addr] <= wgt_wr;
      end
      if (cmd_valid && cmd_ready) begin
         red_rd_ff <= red_mem[cmd_item.addr];
         grn_rd_ff <= grn_mem[cmd_item.addr];
         blu_rd_ff <= blu_mem[cmd_item.addr];
         wgt_rd_ff <= wgt_mem[cmd_item.addr];
      end
   end

   // Sum times 255 over weight times 4096, each fitting 56 bits.
   assign divisor   = {wgt_rd_ff, 16'd0} >> 4;
   assign div_start = (state_ff == ST_READ) && cmd_ff.is_read &&
                      cmd_ff.in_image && (wgt_rd_ff != '0);

   wpa_div u_div_r (.clock, .reset, .start(div_start),
      .dividend({red_rd_ff, 8'd0} - {8'd0, red_rd_ff}),
      .divisor, .done(rd_done), .result(rq));
   wpa_div u_div_g (.clock, .reset, .start(div_start),
      .dividend({grn_rd_ff, 8'd0} - {8'd0, grn_rd_ff}),
      .divisor, .done(gd_done), .result(gq));
   wpa_div u_div_b (.clock, .reset, .start(div_start),
      .dividend({blu_rd_ff, 8'd0} - {8'd0, blu_rd_ff}),
      .divisor, .done(bd_done), .result(bq));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == '1) state_in = ST_IDLE;
         ST_IDLE:  if (cmd_valid && cmd_ready) state_in = ST_READ;
         ST_READ: begin
            if (!cmd_ff.is_read) begin
               state_in = cmd_ff.in_image ? ST_ADD : ST_IDLE;
            end else if (div_start) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_ADD:   state_in = ST_IDLE;
         ST_DIV:   if (rd_done && gd_done && bd_done) state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd_valid && cmd_ready) cmd_ff <= cmd_item;
      rp_ff <= 32'(cmd_ff.red_in) * 32'(cmd_ff.sample_weight);
      gp_ff <= 32'(cmd_ff.green_in) * 32'(cmd_ff.sample_weight);
      bp_ff <= 32'(cmd_ff.blue_in) * 32'(cmd_ff.sample_weight);
      if (state_ff == ST_OUT) begin
         if (div_ok_ff) begin
            rsp_ff <= '{red_out: rq, green_out: gq, blue_out: bq};
         end else begin
            rsp_ff <= '0;
         end
      end
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         div_ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + ADDR_W'(1);
         if (state_ff == ST_READ) div_ok_ff <= div_start;
         if (state_ff == ST_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end
endmodule

[rtl/weighted_pixel_accumulator_core.sv]
// -----------------------------------------------------------------------------
// weighted_pixel_accumulator_core
// A read result is valid once its item has passed the front queue, the film
// store read and, when the three 56-step dividers run, the division. Items
// queue four deep in front. The back end takes one command at a time, and
// a new one only in idle with no response pending, after the film store
// read-modify-write or the dividers. Reset: synchronous; a clearing pass
// zeroes the store, during which no item is taken.
// -----------------------------------------------------------------------------
`include "weighted_pixel_accumulator_core_assert.svh"
module weighted_pixel_accumulator_core #(
   parameter int IMG_WIDTH  = 256,
   parameter int IMG_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   wpa_req_if.sink     req,
   wpa_rsp_if.source   rsp
);
   import wpa_pkg::*;

   logic    cmd_valid, cmd_ready, clearing, fe_ready;
   cmd_type cmd_item;

   assign req.ready = fe_ready && !clearing;

   wpa_front #(.IMG_WIDTH(IMG_WIDTH), .IMG_HEIGHT(IMG_HEIGHT)) u_front (
      .clock, .reset,
      .req_valid(req.valid && !clearing), .req_ready(fe_ready),
      .req_item(req.payload),
      .cmd_valid, .cmd_ready, .cmd_item);

   wpa_back u_back (
      .clock, .reset,
      .cmd_valid, .cmd_ready, .cmd_item,
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_item(rsp.payload),
      .clearing);

   `WPA_ASSERT_IMPL(a_no_accept_clear, clock, reset, clearing |-> !req.ready)
   `WPA_ASSERT_IMPL(a_no_cmd_clear, clock, reset, clearing |-> !cmd_ready)
   `WPA_ASSERT_NORST(a_reset_clears, clock, reset |=> (clearing && !rsp.valid))
endmodule
